// ===== src/ising_metropolis_site_update_macros.svh =====
// ----------------------------------------------------------------------------
// Ising Metropolis site update: assertion macros
// Assertion helpers that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SITE_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SITE_UPDATE_MACROS_SVH

`ifndef SYNTHESIS
`define IMSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define IMSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IMSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define IMSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/imsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Ising Metropolis site update: package
// Shared types, codes and reset values.
// ----------------------------------------------------------------------------
package imsu_pkg;

	localparam int EDGE_DEFAULT = 16;
	localparam int THR_W = 17;
	localparam int RND_W = 16;
	localparam int NUM_THR = 7;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_COMMIT = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_COUPLING_J = 3'd0,
		CFG_ACCEPT_M6  = 3'd1,
		CFG_ACCEPT_M4  = 3'd2,
		CFG_ACCEPT_M2  = 3'd3,
		CFG_ACCEPT_Z0  = 3'd4,
		CFG_ACCEPT_P2  = 3'd5,
		CFG_ACCEPT_P4  = 3'd6,
		CFG_ACCEPT_P6  = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_FETCH,
		ST_EVAL
	} state_t;

	typedef enum logic [2:0] {
		NB_CENTRE,
		NB_XP,
		NB_XM,
		NB_YP,
		NB_YM,
		NB_ZP,
		NB_ZM,
		NB_DRAIN
	} nbr_t;

	typedef logic [NUM_THR-1:0][THR_W-1:0] thr_array_t;

	localparam logic signed [4:0] COUPLING_RESET = 5'sd1;
	localparam thr_array_t THR_RESET = {
		17'd539, 17'd2671, 17'd13231, 17'd65536, 17'd65536, 17'd65536, 17'd65536
	};

	typedef struct packed {
		logic              spin;
		logic              flipped;
		logic signed [7:0] energy_change;
		logic signed [6:0] site_energy;
	} result_t;

endpackage

// ===== src/imsu_energy.sv =====
// ----------------------------------------------------------------------------
// Ising Metropolis site update: energy and acceptance
// Forms s*sum, the energy change, the local energy and the Metropolis test.
// ----------------------------------------------------------------------------
module imsu_energy (
	input  logic                    centre,
	input  logic [2:0]              up_count,
	input  logic                    is_update,
	input  logic signed [4:0]       coupling,
	input  imsu_pkg::thr_array_t    thresholds,
	input  logic [imsu_pkg::RND_W-1:0] random_value,
	output imsu_pkg::result_t       result
);

	logic signed [4:0] sum_up;
	logic signed [3:0] ss;
	logic [2:0]        thr_idx;
	logic signed [4:0] j_sat;
	logic signed [8:0] prod;
	logic signed [8:0] prod_neg;
	logic              accept;

	always_comb begin
		sum_up = $signed({1'b0, up_count, 1'b0}) - 5'sd6;
		ss = centre ? sum_up[3:0] : 4'(-sum_up);
		thr_idx = centre ? up_count : 3'(3'd6 - up_count);
		if (coupling > 5'sd8) begin
			j_sat = 5'sd8;
		end else if (coupling < -5'sd8) begin
			j_sat = -5'sd8;
		end else begin
			j_sat = coupling;
		end
		prod = 9'(j_sat) * 9'(ss);
		prod_neg = -prod;
		accept = prod[8] || ({1'b0, random_value} < thresholds[thr_idx]);
		if (is_update) begin
			result.spin = centre ^ accept;
			result.flipped = accept;
			result.energy_change = $signed({prod[6:0], 1'b0});
			result.site_energy = '0;
		end else begin
			result.spin = centre;
			result.flipped = 1'b0;
			result.energy_change = '0;
			result.site_energy = prod_neg[6:0];
		end
	end

endmodule

// ===== src/ising_metropolis_site_update.sv =====
// ----------------------------------------------------------------------------
// Ising Metropolis site update
// Periodic cubic lattice of one-bit spins in two banks with Metropolis update.
// ----------------------------------------------------------------------------
// Input words carry op, site coordinates, spin_in and random_value over a
// valid/stall channel; result words leave over a second valid/stall channel.
// Write and commit give no result; update and read give one result word.
// Configuration writes use cfg_valid/cfg_ready with a register index and data;
// cfg_ready is always high and writes are expected only while the block idles.
// Both spin banks live in one single-port memory with a registered read, so an
// update or read runs through seven lattice reads (site and six neighbours), a
// drain step to take in the last read, an evaluation step that writes an
// update's new spin into the other bank, and a return to idle to take the next
// word. A write passes through its own write state; a commit completes in idle.
// The result sits in an output register; a stalled result holds the block in
// its evaluation cycle only, so the next word may be accepted while the
// previous result still waits.
// Reset clears control state, sets bank a current and loads the register
// defaults. The lattice itself is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "ising_metropolis_site_update_macros.svh"

module ising_metropolis_site_update #(
	parameter int EDGE = imsu_pkg::EDGE_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [3:0]                 pos_x,
	input  logic [3:0]                 pos_y,
	input  logic [3:0]                 pos_z,
	input  logic                       spin_in,
	input  logic [imsu_pkg::RND_W-1:0] random_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       spin_out,
	output logic                       flipped,
	output logic signed [7:0]          energy_change,
	output logic signed [6:0]          site_energy,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [imsu_pkg::THR_W-1:0] cfg_data
);

	localparam int CW = $clog2(EDGE);
	localparam int SW = $clog2(EDGE * EDGE * EDGE);
	localparam int MEM_DEPTH = 1 << (SW + 1);

	function automatic logic [CW-1:0] mod_edge(input logic [3:0] v);
		logic [6:0] r;
		r = {3'b000, v};
		for (int i = 0; i < 5; i++) begin
			if (r >= 7'(EDGE)) begin
				r = r - 7'(EDGE);
			end
		end
		return r[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
		return (c == CW'(EDGE - 1)) ? '0 : CW'(c + 1'b1);
	endfunction

	function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] c);
		return (c == '0) ? CW'(EDGE - 1) : CW'(c - 1'b1);
	endfunction

	function automatic logic [SW-1:0] site_of(input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [CW-1:0] z);
		return (SW'(x) * SW'(EDGE) + SW'(y)) * SW'(EDGE) + SW'(z);
	endfunction

	imsu_pkg::state_t   state_q, state_d;
	imsu_pkg::nbr_t     step_q;
	imsu_pkg::op_t      op_q;
	logic               bank_q;
	logic [CW-1:0]      x_q, y_q, z_q;
	logic               spin_q;
	logic [imsu_pkg::RND_W-1:0] rnd_q;
	logic signed [4:0]  coupling_q;
	imsu_pkg::thr_array_t thr_q;
	logic               centre_q;
	logic [2:0]         up_cnt_q;
	logic               out_valid_q;
	imsu_pkg::result_t  res_q;
	imsu_pkg::result_t  res_d;

	logic               mem [0:MEM_DEPTH-1];
	logic               mem_we;
	logic [SW:0]        mem_addr;
	logic               mem_wdata;
	logic               rd_data_s1;
	logic               rd_vld_s1;
	imsu_pkg::nbr_t     rd_tag_s1;

	logic               in_accept;
	logic               load_out;
	logic [CW-1:0]      nx, ny, nz;
	logic [SW-1:0]      site_addr;
	logic [SW-1:0]      nbr_addr;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;
	assign load_out = (state_q == imsu_pkg::ST_EVAL) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q <= imsu_pkg::COUPLING_RESET;
			thr_q <= imsu_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (imsu_pkg::cfg_index_t'(cfg_index))
				imsu_pkg::CFG_COUPLING_J: coupling_q <= $signed(cfg_data[4:0]);
				imsu_pkg::CFG_ACCEPT_M6:  thr_q[0] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_M4:  thr_q[1] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_M2:  thr_q[2] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_Z0:  thr_q[3] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_P2:  thr_q[4] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_P4:  thr_q[5] <= cfg_data;
				imsu_pkg::CFG_ACCEPT_P6:  thr_q[6] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q <= imsu_pkg::op_t'(op);
			x_q <= mod_edge(pos_x);
			y_q <= mod_edge(pos_y);
			z_q <= mod_edge(pos_z);
			spin_q <= spin_in;
			rnd_q <= random_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		mem_we = 1'b0;
		mem_wdata = spin_q;
		mem_addr = {bank_q, nbr_addr};
		unique case (state_q)
			imsu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (imsu_pkg::op_t'(op))
						imsu_pkg::OP_WRITE:  state_d = imsu_pkg::ST_WRITE;
						imsu_pkg::OP_COMMIT: state_d = imsu_pkg::ST_IDLE;
						default:             state_d = imsu_pkg::ST_FETCH;
					endcase
				end
			end
			imsu_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				mem_addr = {bank_q, site_addr};
				state_d = imsu_pkg::ST_IDLE;
			end
			imsu_pkg::ST_FETCH: begin
				if (step_q == imsu_pkg::NB_DRAIN) begin
					state_d = imsu_pkg::ST_EVAL;
				end
			end
			imsu_pkg::ST_EVAL: begin
				mem_addr = {~bank_q, site_addr};
				mem_wdata = res_d.spin;
				if (load_out) begin
					mem_we = (op_q == imsu_pkg::OP_UPDATE);
					state_d = imsu_pkg::ST_IDLE;
				end
			end
			default: state_d = imsu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= imsu_pkg::NB_CENTRE;
			bank_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_tag_s1 <= imsu_pkg::NB_CENTRE;
			up_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == imsu_pkg::ST_FETCH) && (step_q != imsu_pkg::NB_DRAIN);
			rd_tag_s1 <= step_q;
			if (in_accept) begin
				step_q <= imsu_pkg::NB_CENTRE;
				up_cnt_q <= '0;
				if (imsu_pkg::op_t'(op) == imsu_pkg::OP_COMMIT) begin
					bank_q <= ~bank_q;
				end
			end else if (state_q == imsu_pkg::ST_FETCH && step_q != imsu_pkg::NB_DRAIN) begin
				step_q <= imsu_pkg::nbr_t'(step_q + 3'd1);
			end
			if (rd_vld_s1 && rd_tag_s1 != imsu_pkg::NB_CENTRE && !in_accept) begin
				up_cnt_q <= up_cnt_q + {2'b00, rd_data_s1};
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_tag_s1 == imsu_pkg::NB_CENTRE) begin
			centre_q <= rd_data_s1;
		end
		if (load_out) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		nx = x_q;
		ny = y_q;
		nz = z_q;
		unique case (step_q)
			imsu_pkg::NB_XP: nx = wrap_inc(x_q);
			imsu_pkg::NB_XM: nx = wrap_dec(x_q);
			imsu_pkg::NB_YP: ny = wrap_inc(y_q);
			imsu_pkg::NB_YM: ny = wrap_dec(y_q);
			imsu_pkg::NB_ZP: nz = wrap_inc(z_q);
			imsu_pkg::NB_ZM: nz = wrap_dec(z_q);
			default: ;
		endcase
	end

	assign site_addr = site_of(x_q, y_q, z_q);
	assign nbr_addr = site_of(nx, ny, nz);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_addr];
	end

	imsu_energy u_energy (
		.centre       (centre_q),
		.up_count     (up_cnt_q),
		.is_update    (op_q == imsu_pkg::OP_UPDATE),
		.coupling     (coupling_q),
		.thresholds   (thr_q),
		.random_value (rnd_q),
		.result       (res_d)
	);

	assign out_valid = out_valid_q;
	assign spin_out = res_q.spin;
	assign flipped = res_q.flipped;
	assign energy_change = res_q.energy_change;
	assign site_energy = res_q.site_energy;

	`IMSU_ASSERT_SAME(a_we_only_write_or_update, clk, arst_n, mem_we,
		(state_q == imsu_pkg::ST_WRITE) ||
		(state_q == imsu_pkg::ST_EVAL && op_q == imsu_pkg::OP_UPDATE),
		"lattice written outside a write or update")
	`IMSU_ASSERT_SAME(a_eval_no_pending_read, clk, arst_n,
		state_q == imsu_pkg::ST_EVAL, !rd_vld_s1 && up_cnt_q <= 3'd6,
		"evaluation started with a lattice read still in flight")
	`IMSU_ASSERT_NEXT(a_commit_swaps, clk, arst_n,
		in_accept && op == imsu_pkg::OP_COMMIT, bank_q != $past(bank_q),
		"commit did not swap the banks")
	`IMSU_ASSERT_NEXT(a_update_fetches, clk, arst_n,
		in_accept && (op == imsu_pkg::OP_UPDATE || op == imsu_pkg::OP_READ),
		state_q == imsu_pkg::ST_FETCH && step_q == imsu_pkg::NB_CENTRE,
		"update or read did not start its neighbour fetch")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the Ising Metropolis site update
// Drives site words (write, update, commit, read) into the block, keeps its own
// copy of both spin banks and of the registers, and checks every result word
// field by field against the predicted spin, flip, energy change and site
// energy. Runs a directed start, then random traffic confined mostly to sites
// whose neighbourhoods are loaded, under several register settings and with
// idle and stall phases on both channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int SITE_COUNT    = 4096;

	localparam imsu_pkg::cfg_index_t THR_REGS [imsu_pkg::NUM_THR] = '{
		imsu_pkg::CFG_ACCEPT_M6, imsu_pkg::CFG_ACCEPT_M4, imsu_pkg::CFG_ACCEPT_M2,
		imsu_pkg::CFG_ACCEPT_Z0, imsu_pkg::CFG_ACCEPT_P2, imsu_pkg::CFG_ACCEPT_P4,
		imsu_pkg::CFG_ACCEPT_P6
	};

	typedef struct {
		imsu_pkg::op_t op;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [3:0]  z;
		logic        spin;
		logic [15:0] rnd;
	} site_word_t;

	typedef logic [11:0] site_list_t [7];
	typedef logic [imsu_pkg::THR_W-1:0] thr_set_t [imsu_pkg::NUM_THR];

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          op;
	logic [3:0]          pos_x;
	logic [3:0]          pos_y;
	logic [3:0]          pos_z;
	logic                spin_in;
	logic [imsu_pkg::RND_W-1:0] random_value;
	logic                out_valid;
	logic                out_stall;
	logic                spin_out;
	logic                flipped;
	logic signed [7:0]   energy_change;
	logic signed [6:0]   site_energy;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [imsu_pkg::THR_W-1:0] cfg_data;

	bit                  bank_spin [2][SITE_COUNT];
	bit                  bank_loaded [2][SITE_COUNT];
	bit                  cur_bank;
	logic [4:0]          coupling_cfg;
	logic [imsu_pkg::THR_W-1:0] accept_thr [imsu_pkg::NUM_THR];
	imsu_pkg::result_t   expected_results [$];
	logic [11:0]         far_site;

	int                  sender_idle_pct;
	int                  stall_pct;
	int                  error_count;
	int                  words_sent;
	int                  update_count;
	int                  read_count;
	int                  results_checked;
	int                  register_writes;
	int                  settings_used;
	int                  quiet_cycles;

	ising_metropolis_site_update u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic site_list_t neighbourhood(logic [3:0] x, logic [3:0] y, logic [3:0] z);
		logic [3:0] xp, xm, yp, ym, zp, zm;
		site_list_t s;
		xp = x + 4'd1;
		xm = x - 4'd1;
		yp = y + 4'd1;
		ym = y - 4'd1;
		zp = z + 4'd1;
		zm = z - 4'd1;
		s[0] = {x, y, z};
		s[1] = {xp, y, z};
		s[2] = {xm, y, z};
		s[3] = {x, yp, z};
		s[4] = {x, ym, z};
		s[5] = {x, y, zp};
		s[6] = {x, y, zm};
		return s;
	endfunction

	function automatic void predict_site_word(site_word_t w);
		site_list_t sites;
		int nsum, ss, j, de, le, k;
		logic centre, accept;
		imsu_pkg::result_t r;
		sites = neighbourhood(w.x, w.y, w.z);
		case (w.op)
			imsu_pkg::OP_WRITE: begin
				bank_spin[cur_bank][sites[0]] = w.spin;
				bank_loaded[cur_bank][sites[0]] = 1'b1;
			end
			imsu_pkg::OP_COMMIT: begin
				cur_bank = cur_bank ^ 1'b1;
			end
			default: begin
				centre = bank_spin[cur_bank][sites[0]];
				nsum = 0;
				for (k = 1; k < 7; k++)
					nsum += bank_spin[cur_bank][sites[k]] ? 1 : -1;
				ss = centre ? nsum : -nsum;
				j = $signed(coupling_cfg);
				if (j > 8)
					j = 8;
				if (j < -8)
					j = -8;
				r = '0;
				if (w.op == imsu_pkg::OP_UPDATE) begin
					de = 2 * j * ss;
					accept = (de < 0) || ({1'b0, w.rnd} < accept_thr[(ss + 6) / 2]);
					r.spin = centre ^ accept;
					r.flipped = accept;
					r.energy_change = de[7:0];
					bank_spin[cur_bank ^ 1'b1][sites[0]] = r.spin;
					bank_loaded[cur_bank ^ 1'b1][sites[0]] = 1'b1;
					update_count++;
				end else begin
					le = -j * ss;
					r.spin = centre;
					r.site_energy = le[6:0];
					read_count++;
				end
				expected_results.insert(expected_results.size(), r);
			end
		endcase
	endfunction

	function automatic site_word_t make_site_word(imsu_pkg::op_t o, logic [3:0] x,
			logic [3:0] y, logic [3:0] z, logic spin, logic [15:0] rnd);
		site_word_t w;
		w.op = o;
		w.x = x;
		w.y = y;
		w.z = z;
		w.spin = spin;
		w.rnd = rnd;
		return w;
	endfunction

	// Most sites come from a small block straddling the wrap in every axis, so
	// neighbourhoods fill quickly; an update or read whose neighbourhood is not
	// yet loaded in the current bank becomes a write of the first missing site.
	function automatic site_word_t next_site_word();
		site_word_t w;
		site_list_t sites;
		logic [3:0] focus [4];
		int pick, k;
		logic found;
		focus = '{4'd14, 4'd15, 4'd0, 4'd1};
		pick = $urandom_range(99);
		if (pick < 70) begin
			w.x = focus[$urandom_range(3)];
			w.y = focus[$urandom_range(3)];
			w.z = focus[$urandom_range(3)];
		end else begin
			if (pick >= 90)
				far_site = 12'($urandom);
			{w.x, w.y, w.z} = far_site;
		end
		pick = $urandom_range(99);
		if (pick < 20)
			w.op = imsu_pkg::OP_WRITE;
		else if (pick < 65)
			w.op = imsu_pkg::OP_UPDATE;
		else if (pick < 95)
			w.op = imsu_pkg::OP_READ;
		else
			w.op = imsu_pkg::OP_COMMIT;
		w.spin = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)
			w.rnd = 16'd0;
		else if (pick < 16)
			w.rnd = 16'hffff;
		else
			w.rnd = 16'($urandom);
		if (w.op == imsu_pkg::OP_UPDATE || w.op == imsu_pkg::OP_READ) begin
			sites = neighbourhood(w.x, w.y, w.z);
			found = 1'b0;
			for (k = 0; k < 7; k++) begin
				if (!found && !bank_loaded[cur_bank][sites[k]]) begin
					found = 1'b1;
					w.op = imsu_pkg::OP_WRITE;
					{w.x, w.y, w.z} = sites[k];
				end
			end
		end
		return w;
	endfunction

	function automatic thr_set_t random_thresholds();
		thr_set_t t;
		int k, pick;
		for (k = 0; k < imsu_pkg::NUM_THR; k++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				t[k] = '0;
			else if (pick < 20)
				t[k] = 17'd65536;
			else if (pick < 25)
				t[k] = '1;
			else
				t[k] = 17'($urandom_range(65536));
		end
		return t;
	endfunction

	function automatic thr_set_t uniform_thresholds(logic [imsu_pkg::THR_W-1:0] value);
		thr_set_t t;
		int k;
		for (k = 0; k < imsu_pkg::NUM_THR; k++)
			t[k] = value;
		return t;
	endfunction

	task automatic send_site_word(site_word_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		pos_x <= w.x;
		pos_y <= w.y;
		pos_z <= w.z;
		spin_in <= w.spin;
		random_value <= w.rnd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_site_word(w);
		words_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(logic [4:0] j, thr_set_t thr);
		int k;
		settle();
		for (k = 0; k <= imsu_pkg::NUM_THR; k++) begin
			cfg_valid <= 1'b1;
			if (k == 0) begin
				cfg_index <= imsu_pkg::CFG_COUPLING_J;
				cfg_data <= {12'd0, j};
			end else begin
				cfg_index <= THR_REGS[k - 1];
				cfg_data <= thr[k - 1];
			end
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (k == 0)
				coupling_cfg = j;
			else
				accept_thr[k - 1] = thr[k - 1];
			register_writes++;
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random_words(int count);
		repeat (count) send_site_word(next_site_word());
	endtask

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result_word();
		imsu_pkg::result_t want;
		if (expected_results.size() == 0) begin
			error_count++;
			$display("%0t: result word with nothing expected, expected none, %s %0d %0d %0d %0d",
				$time, "actual spin, flip, dE, E", spin_out, flipped, energy_change,
				site_energy);
		end else begin
			want = expected_results.pop_front();
			compare_field("spin_out", int'(want.spin), int'(spin_out));
			compare_field("flipped", int'(want.flipped), int'(flipped));
			compare_field("energy_change", int'(want.energy_change), int'(energy_change));
			compare_field("site_energy", int'(want.site_energy), int'(site_energy));
			results_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result_word();
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_directed_cases();
		site_list_t sites;
		int k;
		sender_idle_pct = 0;
		stall_pct = 0;
		sites = neighbourhood(4'd0, 4'd0, 4'd0);
		for (k = 0; k < 7; k++)
			send_site_word(make_site_word(imsu_pkg::OP_WRITE, sites[k][11:8], sites[k][7:4],
				sites[k][3:0], 1'b1, 16'd0));
		send_site_word(make_site_word(imsu_pkg::OP_READ, 4'd0, 4'd0, 4'd0, 1'b0, 16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_UPDATE, 4'd0, 4'd0, 4'd0, 1'b0, 16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_UPDATE, 4'd0, 4'd0, 4'd0, 1'b0, 16'd539));
		send_site_word(make_site_word(imsu_pkg::OP_UPDATE, 4'd0, 4'd0, 4'd0, 1'b0, 16'd538));
		send_site_word(make_site_word(imsu_pkg::OP_UPDATE, 4'd0, 4'd0, 4'd0, 1'b0, 16'd0));
		send_site_word(make_site_word(imsu_pkg::OP_WRITE, 4'd0, 4'd0, 4'd0, 1'b0, 16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_UPDATE, 4'd0, 4'd0, 4'd0, 1'b1, 16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_READ, 4'd0, 4'd0, 4'd0, 1'b1, 16'd0));
		send_site_word(make_site_word(imsu_pkg::OP_WRITE, 4'd15, 4'd15, 4'd15, 1'b1,
			16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_COMMIT, 4'd15, 4'd15, 4'd15, 1'b1,
			16'hffff));
		send_site_word(make_site_word(imsu_pkg::OP_COMMIT, 4'd0, 4'd0, 4'd0, 1'b0, 16'd0));
		send_site_word(make_site_word(imsu_pkg::OP_READ, 4'd0, 4'd0, 4'd0, 1'b0, 16'd0));
	endtask

	task automatic test_default_registers();
		sender_idle_pct = 0;
		stall_pct = 0;
		run_random_words(300);
	endtask

	task automatic test_sender_gaps();
		program_registers(5'($urandom), random_thresholds());
		sender_idle_pct = 45;
		stall_pct = 0;
		run_random_words(300);
	endtask

	task automatic test_receiver_stalls();
		program_registers(5'($urandom), random_thresholds());
		sender_idle_pct = 0;
		stall_pct = 45;
		run_random_words(300);
	endtask

	task automatic test_both_idle();
		program_registers(5'($urandom), random_thresholds());
		sender_idle_pct = 36;
		stall_pct = 36;
		run_random_words(300);
	endtask

	// Codes outside -8..8 must behave as the nearest end of that range.
	task automatic test_coupling_saturation();
		logic [4:0] couplings [7];
		int k;
		couplings = '{5'b01111, 5'b10000, 5'b01001, 5'b10111, 5'b01000, 5'b11000, 5'b00000};
		for (k = 0; k < 7; k++) begin
			program_registers(couplings[k], random_thresholds());
			sender_idle_pct = 36;
			stall_pct = 36;
			run_random_words(40);
		end
	endtask

	task automatic test_threshold_extremes();
		program_registers(5'd1, uniform_thresholds('0));
		sender_idle_pct = 0;
		stall_pct = 0;
		run_random_words(60);
		program_registers(5'b11111, uniform_thresholds('1));
		run_random_words(60);
		program_registers(5'd3, uniform_thresholds(17'd65536));
		run_random_words(60);
		program_registers(5'b11000, uniform_thresholds(17'd65535));
		run_random_words(60);
	endtask

	initial begin
		cur_bank = 1'b0;
		coupling_cfg = imsu_pkg::COUPLING_RESET;
		for (int k = 0; k < imsu_pkg::NUM_THR; k++)
			accept_thr[k] = imsu_pkg::THR_RESET[k];
		far_site = 12'($urandom);
		sender_idle_pct = 0;
		stall_pct = 0;
		error_count = 0;
		words_sent = 0;
		update_count = 0;
		read_count = 0;
		results_checked = 0;
		register_writes = 0;
		settings_used = 1;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= imsu_pkg::OP_WRITE;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		spin_in <= 1'b0;
		random_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= imsu_pkg::CFG_COUPLING_J;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_default_registers();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_coupling_saturation();
		test_threshold_extremes();
		stall_pct = 0;
		settle();

		$display("Sent %0d site words (%0d updates, %0d reads), checked %0d result words.",
			words_sent, update_count, read_count, results_checked);
		$display("Used %0d register settings over %0d register writes, %0d mismatches.",
			settings_used, register_writes, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
